/* sv/rau_pkg.sv */
// ---------------------------------------------------------------------------
// rau_pkg: shared types and constants
// Transfer structs, status and operation codes, and the widths derived
// from the operand width.
// ---------------------------------------------------------------------------
package rau_pkg;

  localparam int WIDTH = 32;
  localparam int OW    = WIDTH;
  localparam int PW    = 2 * WIDTH;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_RED = 3'd4;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef struct packed {
    logic        [2:0]       mode;
    logic signed [WIDTH-1:0] a_num;
    logic signed [WIDTH-1:0] a_den;
    logic signed [WIDTH-1:0] b_num;
    logic        [WIDTH-2:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] res_num;
    logic        [WIDTH-2:0] res_den;
    status_t                 status;
  } out_t;

endpackage

/* sv/rational_arithmetic_unit.sv */
// ---------------------------------------------------------------------------
// rational_arithmetic_unit: exact fraction arithmetic, reduced result
// One item at a time. The exact numerator and denominator are formed with
// a bit-serial multiplier (two or three products), then reduced by a binary
// gcd, whose run time is set by the operand bit patterns, and two restoring
// divisions; a zero result skips the reduction, and error items skip all of
// the arithmetic. A finished result waits in the output register while the
// next item is taken.
// ---------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MSTART, S_MWAIT, S_COMB, S_GCD, S_DN0, S_DN, S_DD0, S_DD, S_CHK, S_FIN
  } state_t;

  localparam logic [PW-1:0] LIM = PW'(1) << (WIDTH - 1);

  state_t        state_r;
  logic [1:0]    ph_r;
  logic [OW-1:0] x_r [3];
  logic [OW-1:0] y_r [3];
  logic [PW-1:0] p_r [3];
  logic          s1_r, s2_r, two_r, sgn_r;
  logic [PW-1:0] n_r, d_r, g_r, qn_r;
  out_t          res_r;
  logic          out_valid_r;
  out_t          out_data_r;

  logic          mul_done, gcd_done, div_done;
  logic [PW-1:0] mul_prod, gcd_val, div_quo;
  logic          gcd_start, div_start;
  logic [PW-1:0] div_n;

  // capture decode
  logic [2:0]    mode_c;
  logic          sna, sda, snb, err_c;
  logic [OW-1:0] ma, mda, mb, dbx;
  logic [OW-1:0] x_c [3];
  logic [OW-1:0] y_c [3];
  logic          s1_c, s2_c, two_c;

  always_comb begin
    mode_c = (in_data.mode > MODE_RED) ? MODE_RED : in_data.mode;
    sna    = in_data.a_num[WIDTH-1];
    sda    = in_data.a_den[WIDTH-1];
    snb    = in_data.b_num[WIDTH-1];
    ma     = sna ? (~in_data.a_num + 1'b1) : in_data.a_num;
    mda    = sda ? (~in_data.a_den + 1'b1) : in_data.a_den;
    mb     = snb ? (~in_data.b_num + 1'b1) : in_data.b_num;
    dbx    = {1'b0, in_data.b_den};
    err_c  = (in_data.a_den == '0) ||
             ((mode_c != MODE_RED) && (in_data.b_den == '0)) ||
             ((mode_c == MODE_DIV) && (in_data.b_num == '0));
    x_c[0] = ma;
    y_c[0] = dbx;
    x_c[1] = mb;
    y_c[1] = mda;
    x_c[2] = mda;
    y_c[2] = dbx;
    s1_c   = sna ^ sda;
    s2_c   = snb ^ (mode_c == MODE_SUB);
    two_c  = 1'b0;
    case (mode_c)
      MODE_ADD, MODE_SUB: two_c = 1'b1;
      MODE_MUL: begin
        y_c[0] = mb;
        s1_c   = sna ^ sda ^ snb;
      end
      MODE_DIV: begin
        y_c[2] = mb;
        s1_c   = sna ^ sda ^ snb;
      end
      default: begin
        y_c[0] = OW'(1);
        y_c[2] = OW'(1);
      end
    endcase
  end

  // numerator combine
  logic [PW-1:0] nmag_c;
  logic          nsgn_c;

  always_comb begin
    nmag_c = p_r[0];
    nsgn_c = s1_r;
    if (two_r) begin
      if (s1_r == s2_r) begin
        nmag_c = p_r[0] + p_r[1];
      end else if (p_r[0] >= p_r[1]) begin
        nmag_c = p_r[0] - p_r[1];
      end else begin
        nmag_c = p_r[1] - p_r[0];
        nsgn_c = s2_r;
      end
    end
  end

  assign gcd_start = (state_r == S_COMB) && (nmag_c != '0);
  assign div_start = (state_r == S_DN0) || (state_r == S_DD0);
  assign div_n     = (state_r == S_DN0) ? n_r : d_r;

  rau_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_MSTART),
    .op_a  (x_r[ph_r]),
    .op_b  (y_r[ph_r]),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  rau_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .op_x  (nmag_c),
    .op_y  (p_r[2]),
    .done  (gcd_done),
    .gcd   (gcd_val)
  );

  rau_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .op_n  (div_n),
    .op_d  (g_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  logic over_c;
  assign over_c = (sgn_r ? (qn_r > LIM) : (qn_r > LIM - 1'b1)) || (d_r > LIM - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ph_r        <= '0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            res_r.res_num <= '0;
            res_r.res_den <= (WIDTH-1)'(1);
            res_r.status  <= err_c ? ST_DIV0 : ST_OK;
            ph_r          <= '0;
            for (int i = 0; i < 3; i++) begin
              x_r[i] <= x_c[i];
              y_r[i] <= y_c[i];
            end
            s1_r  <= s1_c;
            s2_r  <= s2_c;
            two_r <= two_c;
            if (err_c) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_MSTART;
            end
          end
        end
        S_MSTART: state_r <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            p_r[ph_r] <= mul_prod;
            if (ph_r == 2'd2) begin
              state_r <= S_COMB;
            end else begin
              state_r <= S_MSTART;
              if (ph_r == 2'd0 && !two_r) begin
                ph_r <= 2'd2;
              end else begin
                ph_r <= ph_r + 1'b1;
              end
            end
          end
        end
        S_COMB: begin
          n_r   <= nmag_c;
          sgn_r <= nsgn_c;
          d_r   <= p_r[2];
          state_r <= (nmag_c == '0) ? S_FIN : S_GCD;
        end
        S_GCD: begin
          if (gcd_done) begin
            g_r     <= gcd_val;
            state_r <= S_DN0;
          end
        end
        S_DN0: state_r <= S_DN;
        S_DN: begin
          if (div_done) begin
            qn_r    <= div_quo;
            state_r <= S_DD0;
          end
        end
        S_DD0: state_r <= S_DD;
        S_DD: begin
          if (div_done) begin
            d_r     <= div_quo;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (over_c) begin
            res_r.status <= ST_OVF;
          end else begin
            res_r.res_num <= sgn_r ? (~qn_r[WIDTH-1:0] + 1'b1) : qn_r[WIDTH-1:0];
            res_r.res_den <= d_r[WIDTH-2:0];
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/rau_mul.sv */
// ---------------------------------------------------------------------------
// rau_mul: bit-serial multiplier
// Shift-add over one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module rau_mul import rau_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [OW-1:0] op_a,
  input  logic [OW-1:0] op_b,
  output logic          done,
  output logic [PW-1:0] prod
);

  localparam int CW = $clog2(OW) + 1;

  logic [PW-1:0] acc_r;
  logic [PW-1:0] sh_r;
  logic [OW-1:0] mb_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        acc_r  <= '0;
        sh_r   <= PW'(op_a);
        mb_r   <= op_b;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (mb_r[0]) begin
          acc_r <= acc_r + sh_r;
        end
        sh_r  <= sh_r << 1;
        mb_r  <= mb_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(OW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

/* sv/rau_gcd.sv */
// ---------------------------------------------------------------------------
// rau_gcd: binary gcd unit
// Strips common factors of two, runs subtract-and-halve steps one per
// cycle, then shifts the common power of two back in. Inputs nonzero.
// ---------------------------------------------------------------------------
module rau_gcd import rau_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [PW-1:0] op_x,
  input  logic [PW-1:0] op_y,
  output logic          done,
  output logic [PW-1:0] gcd
);

  localparam int KW = $clog2(PW) + 1;

  typedef enum logic [1:0] {G_IDLE, G_TWO, G_LOOP, G_SHL} gstate_t;

  gstate_t       state_r;
  logic [PW-1:0] a_r;
  logic [PW-1:0] b_r;
  logic [KW-1:0] k_r;
  logic          done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        G_IDLE: begin
          if (start) begin
            a_r     <= op_x;
            b_r     <= op_y;
            k_r     <= '0;
            state_r <= G_TWO;
          end
        end
        G_TWO: begin
          if (a_r[0] || b_r[0]) begin
            state_r <= G_LOOP;
          end else begin
            a_r <= a_r >> 1;
            b_r <= b_r >> 1;
            k_r <= k_r + 1'b1;
          end
        end
        G_LOOP: begin
          if (a_r == b_r) begin
            state_r <= G_SHL;
          end else if (!a_r[0]) begin
            a_r <= a_r >> 1;
          end else if (!b_r[0]) begin
            b_r <= b_r >> 1;
          end else if (a_r > b_r) begin
            a_r <= a_r - b_r;
          end else begin
            b_r <= b_r - a_r;
          end
        end
        G_SHL: begin
          if (k_r == '0) begin
            done_r  <= 1'b1;
            state_r <= G_IDLE;
          end else begin
            a_r <= a_r << 1;
            k_r <= k_r - 1'b1;
          end
        end
        default: state_r <= G_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign gcd  = a_r;

endmodule

/* sv/rau_div.sv */
// ---------------------------------------------------------------------------
// rau_div: restoring divider
// One quotient bit per cycle.
// ---------------------------------------------------------------------------
module rau_div import rau_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [PW-1:0] op_n,
  input  logic [PW-1:0] op_d,
  output logic          done,
  output logic [PW-1:0] quo
);

  localparam int CW = $clog2(PW) + 1;

  logic [PW:0]   rem_r;
  logic [PW-1:0] q_r;
  logic [PW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [PW:0]   trial;

  assign trial = {rem_r[PW-1:0], q_r[PW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        q_r    <= op_n;
        d_r    <= op_d;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (trial >= {1'b0, d_r}) begin
          rem_r <= trial - {1'b0, d_r};
          q_r   <= {q_r[PW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[PW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(PW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: rational_arithmetic_unit
// Feeds directed and random fraction pairs through the valid/stall input
// channel, predicts every reduced result and status in a scoreboard, and
// checks each result transfer under random and long output back-pressure.
// ---------------------------------------------------------------------------
module testbench;
  import rau_pkg::*;

  class fraction_scoreboard;
    out_t pending[$];
    int   errors;

    function longint gcd_mag(longint x, longint y);
      bit [63:0] a, b, t;
      a = (x < 0) ? -x : x;
      b = (y < 0) ? -y : y;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return longint'(a);
    endfunction

    function void normalise(inout longint n, inout longint d);
      longint g;
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      if (n == 0) begin
        d = 1;
        return;
      end
      g = gcd_mag(n, d);
      n = n / g;
      d = d / g;
    endfunction

    function out_t fraction_result(in_t x);
      longint na, da, nb, db, rn, rd, g1, g2, t;
      logic [2:0] m;
      status_t st;
      out_t r;
      m  = (x.mode > MODE_RED) ? MODE_RED : x.mode;
      na = longint'(x.a_num);
      da = longint'(x.a_den);
      nb = longint'(x.b_num);
      db = longint'(x.b_den);
      rn = 0;
      rd = 1;
      st = ST_OK;
      if (da == 0 || (m != MODE_RED && db == 0)) begin
        st = ST_DIV0;
      end else begin
        normalise(na, da);
        if (m != MODE_RED) normalise(nb, db);
        case (m)
          MODE_ADD, MODE_SUB: begin
            if (m == MODE_SUB) nb = -nb;
            g1 = gcd_mag(da, db);
            t  = na * (db / g1) + (da / g1) * nb;
            g2 = gcd_mag(t, g1);
            rn = t / g2;
            rd = (da / g1) * (db / g2);
          end
          MODE_MUL: begin
            if (na != 0 && nb != 0) begin
              g1 = gcd_mag(na, db);
              g2 = gcd_mag(da, nb);
              rn = (na / g1) * (nb / g2);
              rd = (da / g2) * (db / g1);
            end
          end
          MODE_DIV: begin
            if (nb == 0) begin
              st = ST_DIV0;
            end else if (na != 0) begin
              g1 = gcd_mag(na, nb);
              g2 = gcd_mag(da, db);
              rn = (na / g1) * (db / g2);
              rd = (da / g2) * (nb / g1);
              if (rd < 0) begin
                rn = -rn;
                rd = -rd;
              end
            end
          end
          default: begin
            rn = na;
            rd = da;
          end
        endcase
        if (st == ST_OK) begin
          if (rn == 0) rd = 1;
          if (rn > 64'sd2147483647 || rn < -64'sd2147483648 || rd > 64'sd2147483647)
            st = ST_OVF;
        end
      end
      if (st != ST_OK) begin
        rn = 0;
        rd = 1;
      end
      r.res_num = rn[31:0];
      r.res_den = rd[30:0];
      r.status  = st;
      return r;
    endfunction

    function void note_input(in_t x);
      pending.push_back(fraction_result(x));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: %0d/%0d status %0d",
               got.res_num, got.res_den, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.res_num !== want.res_num) begin
        $error("res_num: expected %0d, got %0d", want.res_num, got.res_num);
        errors++;
      end
      if (got.res_den !== want.res_den) begin
        $error("res_den: expected %0d, got %0d", want.res_den, got.res_den);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  fraction_scoreboard sb;
  int send_idle;
  int recv_idle;
  bit hold_req;
  bit hold_used = 1'b0;
  int hold_cnt  = 0;

  rational_arithmetic_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #(64'd100_000_000);
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_cnt  = 3000;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  task automatic send_item(in_t x);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [2:0] m, int an, int ad, int bn, int bd);
    in_t x;
    x.mode  = m;
    x.a_num = an;
    x.a_den = ad;
    x.b_num = bn;
    x.b_den = 31'(bd);
    send_item(x);
  endtask

  function automatic int rand_operand();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 40) - 20;
      1:       return int'($urandom_range(0, 2000)) - 1000;
      2:       return (int'($urandom_range(0, 200)) - 100) * int'($urandom_range(1, 5000));
      3:       return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    in_t x;
    x.mode  = ($urandom_range(0, 19) < 18) ? 3'($urandom_range(0, 4))
                                           : 3'($urandom_range(5, 7));
    x.a_num = rand_operand();
    x.a_den = rand_operand();
    if ($urandom_range(0, 3) != 0 && x.a_den < 0) x.a_den = -x.a_den;
    if ($urandom_range(0, 40) == 0) x.a_den = 0;
    x.b_num = rand_operand();
    case ($urandom_range(0, 5))
      0:       x.b_den = 31'($urandom_range(1, 20));
      1:       x.b_den = 31'($urandom_range(1, 5000));
      2:       x.b_den = ($urandom_range(0, 30) == 0) ? 31'd0 : 31'h7fff_ffff;
      default: x.b_den = 31'($urandom);
    endcase
    send_item(x);
  endtask

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    hold_req  = 1'b0;
    send_idle = 12;
    recv_idle = 74;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_fields(MODE_ADD, 1, 2, 1, 3);
    send_fields(MODE_SUB, 1, 2, 1, 2);
    send_fields(MODE_MUL, -6, 4, 10, 9);
    send_fields(MODE_DIV, 3, 7, -9, 14);
    send_fields(MODE_RED, 12, -18, 0, 0);
    send_fields(MODE_RED, 32'h8000_0000, -1, 5, 5);
    send_fields(MODE_RED, 32'h8000_0000, 32'h8000_0000, 0, 1);
    send_fields(MODE_RED, 0, -7, 0, 1);
    send_fields(MODE_ADD, 5, 0, 1, 1);
    send_fields(MODE_MUL, 5, 3, 1, 0);
    send_fields(MODE_RED, 5, 0, 1, 0);
    send_fields(MODE_DIV, 5, 3, 0, 4);
    send_fields(MODE_DIV, 0, 3, 2, 4);
    send_fields(MODE_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    send_fields(MODE_SUB, 32'h8000_0000, 1, 32'h7fff_ffff, 1);
    send_fields(MODE_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
    send_fields(MODE_DIV, 1, 32'h7fff_ffff, 1, 32'h7fff_ffff);
    send_fields(MODE_ADD, 1, 32'h7fff_fffe, 1, 32'h7fff_ffff);
    send_fields(MODE_ADD, 4, 8, 6, 12);
    send_fields(3'd5, 10, 4, 0, 0);
    send_fields(3'd6, -9, -3, 1, 1);
    send_fields(3'd7, 7, 7, 1, 1);
    send_fields(MODE_SUB, 3, 5, 3, 5);

    repeat (240) send_random();
    send_idle = 74;
    recv_idle = 12;
    repeat (240) send_random();
    send_idle = 0;
    recv_idle = 0;
    hold_req  = 1'b1;
    repeat (250) send_random();
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
